[sv/tlpq_pkg.sv]
package tlpq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned FillW    = 7;
  localparam int unsigned StatusW  = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  localparam logic [LevelW-1:0] LEVEL_TOP = '1;

  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] level;
    logic [DataW-1:0]  data;
  } tlpq_entry_t;

  typedef struct packed {
    logic        enq;
    logic        deq;
    tlpq_entry_t ins;
  } tlpq_ctrl_t;

endpackage

[sv/tlpq_cell.sv]
module tlpq_cell
  import tlpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tlpq_ctrl_t  ctrl_i,
  input  tlpq_entry_t prev_i,
  input  tlpq_entry_t next_i,
  output tlpq_entry_t entry_o
);

  tlpq_entry_t entry_q, entry_d;

  // Cells stay sorted by level, highest first, arrival order within a level.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.deq) begin
      entry_d = next_i;
    end else if (ctrl_i.enq) begin
      priority if (entry_q.valid && (entry_q.level >= ctrl_i.ins.level)) begin
        entry_d = entry_q;
      end else if (prev_i.valid && (prev_i.level >= ctrl_i.ins.level)) begin
        entry_d = ctrl_i.ins;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

[sv/three_level_priority_queue_top.sv]
// The result of an accepted item is registered and shows on the master side in the cycle after.
// Throughput: one item per cycle while the master side takes results; each cell of the row decides its next
// content from its own level and its two neighbors in that same cycle.
// Reset (rst_ni low, asynchronous) empties the queue and the output register;
// the block takes items in the first cycle after reset.
module three_level_priority_queue_top
  import tlpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // in_data[31:0], in_priority[33:32], zero pad
  input  logic [0:0]          s_axis_tuser,  // kind[0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,  // out_data[31:0], out_priority[33:32],
                                             // fill_count[40:34], zero pad
  output logic [StatusW-1:0]  m_axis_tuser   // status[1:0]
);

  tlpq_entry_t cells [Capacity];
  tlpq_entry_t prevs [Capacity];
  tlpq_entry_t nexts [Capacity];
  tlpq_ctrl_t  ctrl;

  logic              in_fire;
  logic              kind;
  logic              full;
  logic              empty;
  logic              out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [DataW-1:0]  data_q, data_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  cnt_q, cnt_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser[0];
  assign full          = cells[Capacity-1].valid;
  assign empty         = !cells[0].valid;

  assign ctrl.enq       = in_fire && (kind == KIND_ENQ) && !full;
  assign ctrl.deq       = in_fire && (kind == KIND_DEQ) && !empty;
  assign ctrl.ins.valid = 1'b1;
  assign ctrl.ins.data  = s_axis_tdata[DataW-1:0];
  assign ctrl.ins.level = s_axis_tdata[DataW+LevelW-1:DataW];

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    if (g == 0) begin : g_head
      // top level ranks at or above any insert, so the head takes a new item unless its own entry ranks at or above it
      assign prevs[g] = '{valid: 1'b1, level: LEVEL_TOP, data: '0};
    end else begin : g_mid
      assign prevs[g] = cells[g-1];
    end
    if (g == Capacity - 1) begin : g_tail
      assign nexts[g] = '0;
    end else begin : g_body
      assign nexts[g] = cells[g+1];
    end

    tlpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prevs[g]),
      .next_i  (nexts[g]),
      .entry_o (cells[g])
    );
  end

  always_comb begin
    cnt_d    = cnt_q;
    status_d = ST_OK;
    data_d   = '0;
    level_d  = '0;
    priority if (kind == KIND_ENQ) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        cnt_d = cnt_q + FillW'(1);
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      cnt_d   = cnt_q - FillW'(1);
      data_d  = cells[0].data;
      level_d = cells[0].level;
    end
    fill_d = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_fire) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      data_q   <= data_d;
      level_q  <= level_d;
      fill_q   <= fill_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, fill_q, level_q, data_q};

endmodule

[sv/tlpq_checker.sv]
module tlpq_checker
  import tlpq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [39:0]        s_axis_tdata,
  input logic [0:0]         s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [47:0]        m_axis_tdata,
  input logic [StatusW-1:0] m_axis_tuser
);

  logic [FillW-1:0] fill;
  assign fill = m_axis_tdata[40:34];

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_ready_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output free");

  a_no_payload_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_EMPTY))
      |-> (m_axis_tdata[33:0] == 34'd0))
    else $error("payload on full or empty status");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (fill == '0))
    else $error("empty status with nonzero count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fill <= FillW'(Capacity)) && (m_axis_tuser != 2'd3))
    else $error("count or status out of range");

endmodule

bind three_level_priority_queue_top tlpq_checker u_tlpq_checker (.*);

[tb/sv/testbench.sv]
module testbench;
  import tlpq_pkg::*;

  localparam int unsigned PhaseItems = 350;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  localparam logic [LevelW-1:0] LVL_ZERO = 2'd0;
  localparam logic [LevelW-1:0] LVL_LOW  = 2'd1;
  localparam logic [LevelW-1:0] LVL_MED  = 2'd2;
  localparam logic [LevelW-1:0] LVL_HIGH = LEVEL_TOP;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   data;
    logic [LevelW-1:0]  level;
    logic [FillW-1:0]   fill;
  } pq_result_t;

  typedef struct {
    logic [DataW-1:0]  data;
    logic [LevelW-1:0] level;
  } pq_slot_t;

  typedef struct {
    logic              kind;
    logic [DataW-1:0]  data;
    logic [LevelW-1:0] level;
    bit                fixed;
    pq_result_t        want;
  } op_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // in_data[31:0], in_priority[33:32], zero pad
  logic [0:0]  s_axis_tuser  = '0;  // kind[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // out_data[31:0], out_priority[33:32], fill_count[40:34]
  logic [StatusW-1:0] m_axis_tuser; // status[1:0]

  pq_slot_t   stored_entries[$];
  pq_result_t due_results[$];
  op_row_t    op_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  bit          row_fixed     = 1'b0;
  pq_result_t  row_want      = '0;

  int unsigned n_mismatch = 0;
  int unsigned n_sent     = 0;
  int unsigned n_results  = 0;
  int unsigned n_full     = 0;
  int unsigned n_empty    = 0;
  int unsigned n_lvl_zero = 0;
  int unsigned peak_fill  = 0;
  int unsigned cycles     = 0;

  three_level_priority_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // stable priority queue: earliest entry of the highest level leaves first
  function automatic pq_result_t apply_op(logic kind, logic [DataW-1:0] word,
                                          logic [LevelW-1:0] level);
    pq_result_t r;
    pq_slot_t   s;
    int         pick;
    r = '0;
    r.status = ST_OK;
    if (kind == KIND_ENQ) begin
      if (stored_entries.size() >= Capacity) begin
        r.status = ST_FULL;
      end else begin
        s.data  = word;
        s.level = level;
        stored_entries.push_back(s);
      end
    end else if (stored_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pick = 0;
      for (int i = 1; i < stored_entries.size(); i++) begin
        if (stored_entries[i].level > stored_entries[pick].level) pick = i;
      end
      r.data  = stored_entries[pick].data;
      r.level = stored_entries[pick].level;
      stored_entries.delete(pick);
    end
    r.fill = FillW'(stored_entries.size());
    return r;
  endfunction

  function automatic op_row_t mk_row(logic kind, logic [DataW-1:0] word,
                                     logic [LevelW-1:0] level, bit fixed,
                                     logic [StatusW-1:0] st, logic [DataW-1:0] od,
                                     logic [LevelW-1:0] ol, logic [FillW-1:0] fill);
    op_row_t r;
    r.kind  = kind;
    r.data  = word;
    r.level = level;
    r.fixed = fixed;
    r.want  = '{status: st, data: od, level: ol, fill: fill};
    return r;
  endfunction

  task automatic send_item(logic kind, logic [DataW-1:0] word, logic [LevelW-1:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, level, word};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      hold_req      = 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    pq_result_t want;
    pq_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_op(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[33:32]);
        if (row_fixed) want = row_want;
        due_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.data   = m_axis_tdata[31:0];
        got.level  = m_axis_tdata[33:32];
        got.fill   = m_axis_tdata[40:34];
        n_results++;
        if (got.status == ST_FULL) n_full++;
        if (got.status == ST_EMPTY) n_empty++;
        if (got.status == ST_OK && m_axis_tdata[33:32] == LVL_ZERO && got.data != 0) n_lvl_zero++;
        if (got.fill > peak_fill) peak_fill = got.fill;
        if (due_results.size() == 0) begin
          if (n_mismatch < ReportMax)
            $display("[%0d] unexpected result: status %0d data %h level %0d fill %0d",
                     cycles, got.status, got.data, got.level, got.fill);
          n_mismatch++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (n_mismatch < ReportMax)
              $display("[%0d] mismatch: exp status %0d data %h level %0d fill %0d, %s",
                       cycles, want.status, want.data, want.level, want.fill,
                       $sformatf("got status %0d data %h level %0d fill %0d",
                                 got.status, got.data, got.level, got.fill));
            n_mismatch++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned       burst_no;
    int unsigned       burst_len;
    int unsigned       enq_pct;
    int unsigned       sent;
    logic              kind;
    logic [DataW-1:0]  word;
    logic [LevelW-1:0] level;

    // reset behavior, extremes, level ordering, FIFO order within a level
    op_rows.push_back(mk_row(KIND_DEQ, 32'h5A5A_5A5A, LVL_HIGH, 1, ST_EMPTY, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h7FFF_FFFF, LVL_LOW, 1, ST_OK, '0, LVL_ZERO, 1));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h8000_0000, LVL_HIGH, 1, ST_OK, '0, LVL_ZERO, 2));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0000, LVL_ZERO, 1, ST_OK, '0, LVL_ZERO, 3));
    op_rows.push_back(mk_row(KIND_ENQ, 32'hFFFF_FFFF, LVL_MED, 1, ST_OK, '0, LVL_ZERO, 4));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h1234_5678, LVL_HIGH, 1, ST_OK, '0, LVL_ZERO, 5));
    op_rows.push_back(mk_row(KIND_ENQ, 32'hA5A5_A5A5, LVL_LOW, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_DEQ, 32'hFFFF_FFFF, LVL_ZERO, 1,
                             ST_OK, 32'h8000_0000, LVL_HIGH, 5));
    op_rows.push_back(mk_row(KIND_DEQ, 32'h0000_0000, LVL_HIGH, 1,
                             ST_OK, 32'h1234_5678, LVL_HIGH, 4));
    op_rows.push_back(mk_row(KIND_DEQ, 32'hDEAD_BEEF, LVL_MED, 1,
                             ST_OK, 32'hFFFF_FFFF, LVL_MED, 3));
    op_rows.push_back(mk_row(KIND_DEQ, 32'h0000_0001, LVL_LOW, 1,
                             ST_OK, 32'h7FFF_FFFF, LVL_LOW, 2));
    op_rows.push_back(mk_row(KIND_DEQ, 32'h0, LVL_ZERO, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_DEQ, 32'h0, LVL_ZERO, 1, ST_OK, 32'h0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_DEQ, 32'hFFFF_FFFF, LVL_HIGH, 1, ST_EMPTY, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0010, LVL_ZERO, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0011, LVL_ZERO, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0012, LVL_LOW, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0013, LVL_MED, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0014, LVL_MED, 0, ST_OK, '0, LVL_ZERO, 0));
    op_rows.push_back(mk_row(KIND_ENQ, 32'h0000_0015, LVL_HIGH, 0, ST_OK, '0, LVL_ZERO, 0));
    for (int i = 0; i < 5; i++)
      op_rows.push_back(mk_row(KIND_DEQ, 32'h0, LVL_ZERO, 0, ST_OK, '0, LVL_ZERO, 0));

    send_idle_pct = 24;
    recv_idle_pct = 72;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (op_rows[i]) begin
      row_fixed = op_rows[i].fixed;
      row_want  = op_rows[i].want;
      send_item(op_rows[i].kind, op_rows[i].data, op_rows[i].level);
    end
    row_fixed = 1'b0;

    burst_no = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        burst_len = $urandom_range(40, 90);
        case (burst_no % 4)
          0:       enq_pct = 95;
          2:       enq_pct = 10;
          default: enq_pct = 50;
        endcase
        burst_no++;
        for (int j = 0; j < burst_len && sent < PhaseItems; j++) begin
          kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
          case ($urandom_range(7))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'h0000_0000;
            3:       word = 32'hFFFF_FFFF;
            default: word = $urandom();
          endcase
          level = ($urandom_range(9) == 0) ? LVL_ZERO : LevelW'($urandom_range(1, 3));
          send_item(kind, word, level);
          sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    n_mismatch += due_results.size();

    $display("%0d items sent, %0d results checked, %0d mismatches",
             n_sent, n_results, n_mismatch);
    $display("full drops %0d, empty dequeues %0d, peak fill %0d, one long output stall",
             n_full, n_empty, peak_fill);
    if (n_mismatch == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/tlpq_pkg.sv
sv/tlpq_cell.sv
sv/three_level_priority_queue_top.sv
sv/tlpq_checker.sv
tb/sv/testbench.sv
